>>> rtl/core/wis_pkg.sv
// shared types and constants of the weighted index sampler
package wis_pkg;

  localparam int unsigned DEF_MAX_ENTRIES = 1024;
  localparam int unsigned DEF_WEIGHT_BITS = 32;

  localparam int unsigned ACTIVE_W   = 11;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 11'd1024;

  // register index from byte address bits above the word offset
  localparam logic REG_ACTIVE_ENTRIES = 1'b0;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_DRAW  = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [9:0]  entry_index;
    logic [31:0] weight_value;
    logic [31:0] uniform_fraction;
  } req_t;

  typedef struct packed {
    logic [9:0]  picked_index;
    logic [41:0] total_weight;
    logic        was_draw;
  } rsp_t;

endpackage

>>> rtl/core/wis_ram.sv
// simple dual port memory with one write and one registered read port
module wis_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/weighted_index_sampler.sv
// top level of the weighted index sampler: sequencer, shared multiplier, search
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+------------------------------
//  request   | in        | start_i high, busy_o low| req_i (operation, index, ...)
//  result    | out       | done_o one-cycle strobe | rsp_o (pick, total, was_draw)
//  config    | in / out  | apb write, pready high  | active_entries at byte addr 0
//
// a weight write stores the entry at the accepting edge and the acknowledge
// strobes in the next cycle, with busy_o staying low
// a draw rebuilds the prefix sums first when they are stale, then forms the
// pivot and searches the n active entries: the rebuild walks the weight memory
// one entry a cycle, the pivot uses one 32x32 multiplier twice, and each search
// step reads the prefix memory in S_RD and does the compare in S_CMP
// a draw with a zero total skips the multiply and search and answers entry 0
// reset clears control state only, the two memories hold garbage until written
// results cannot be stalled, done_o is a single-cycle strobe
module weighted_index_sampler #(
  parameter int unsigned MAX_ENTRIES = wis_pkg::DEF_MAX_ENTRIES,
  parameter int unsigned WEIGHT_BITS = wis_pkg::DEF_WEIGHT_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  wis_pkg::req_t                 req_i,
  output logic                          busy_o,
  output logic                          done_o,
  output wis_pkg::rsp_t                 rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wis_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [wis_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [wis_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready
);

  import wis_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned SUM_W = WEIGHT_BITS + IDX_W;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REBLD  = 3'd1;
  localparam logic [2:0] S_MUL_LO = 3'd2;
  localparam logic [2:0] S_MUL_HI = 3'd3;
  localparam logic [2:0] S_RD     = 3'd4;
  localparam logic [2:0] S_CMP    = 3'd5;

  // control state
  logic [2:0]          state_q, state_d;
  logic [ACTIVE_W-1:0] active_q, active_d;
  logic                stale_q, stale_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic                pend_q, pend_d;
  logic                done_q, done_d;

  // datapath registers
  logic [SUM_W-1:0]    run_q, run_d;
  logic [CNT_W-1:0]    rd_cnt_q, rd_cnt_d;
  logic [IDX_W-1:0]    pend_idx_q, pend_idx_d;
  logic [31:0]         u_q, u_d;
  logic [63:0]         prod_q, prod_d;
  logic [IDX_W-1:0]    lo_q, lo_d;
  logic [IDX_W-1:0]    hi_q, hi_d;
  logic [IDX_W-1:0]    mid_q, mid_d;
  rsp_t                rsp_q, rsp_d;

  // memory ports
  logic                w_we;
  logic [IDX_W-1:0]    w_waddr;
  logic [WEIGHT_BITS-1:0] w_wdata;
  logic [WEIGHT_BITS-1:0] w_rdata;
  logic                p_we;
  logic [SUM_W-1:0]    p_rdata;

  // misc
  logic                accept;
  logic                cfg_wr;
  logic [31:0]         act_ext;
  logic [CNT_W-1:0]    n_act;
  logic                in_range;
  logic                issue;
  logic [SUM_W-1:0]    run_nx;
  logic [63:0]         t64;
  logic [31:0]         mul_b;
  logic [63:0]         mul_p;
  logic [IDX_W-1:0]    span;
  logic [IDX_W-1:0]    mid_c;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // config port, register decode ignores the byte offset
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[CFG_ADDR_W-1] == REG_ACTIVE_ENTRIES);
  assign prdata = (paddr[CFG_ADDR_W-1] == REG_ACTIVE_ENTRIES) ?
                  CFG_DATA_W'(active_q) : '0;

  // active count clamped to 1..MAX_ENTRIES
  assign act_ext = 32'(active_q);
  always_comb begin
    priority if (act_ext == 32'd0) begin
      n_act = CNT_W'(1);
    end else if (act_ext > 32'(MAX_ENTRIES)) begin
      n_act = CNT_W'(MAX_ENTRIES);
    end else begin
      n_act = CNT_W'(act_ext);
    end
  end

  // weight write path
  assign in_range = 32'(req_i.entry_index) < 32'(MAX_ENTRIES);
  assign w_we     = accept && (req_i.operation == OP_WRITE) && in_range;
  assign w_waddr  = IDX_W'(req_i.entry_index);
  assign w_wdata  = WEIGHT_BITS'(req_i.weight_value);

  // rebuild walk: one weight read issued per cycle, its prefix written in the cycle after
  assign issue  = (state_q == S_REBLD) && (rd_cnt_q < n_act);
  assign run_nx = run_q + SUM_W'(w_rdata);
  assign p_we   = (state_q == S_REBLD) && pend_q;

  // shared 32x32 multiplier: low half of the total first, then the high half
  assign t64   = 64'(sum_q);
  assign mul_b = (state_q == S_MUL_LO) ? t64[31:0] : t64[63:32];
  assign mul_p = u_q * mul_b;

  // search midpoint
  assign span  = hi_q - lo_q;
  assign mid_c = lo_q + (span >> 1);

  always_comb begin
    state_d    = state_q;
    active_d   = active_q;
    stale_d    = stale_q;
    sum_d      = sum_q;
    pend_d     = pend_q;
    done_d     = 1'b0;
    run_d      = run_q;
    rd_cnt_d   = rd_cnt_q;
    pend_idx_d = pend_idx_q;
    u_d        = u_q;
    prod_d     = prod_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    mid_d      = mid_q;
    rsp_d      = rsp_q;

    if (cfg_wr) begin
      active_d = pwdata[ACTIVE_W-1:0];
      stale_d  = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          u_d = req_i.uniform_fraction;
          if (req_i.operation == OP_WRITE) begin
            // acknowledge carries the last rebuilt total, maybe stale
            if (in_range) begin
              stale_d = 1'b1;
            end
            rsp_d.picked_index = '0;
            rsp_d.total_weight = 42'(sum_q);
            rsp_d.was_draw     = 1'b0;
            done_d             = 1'b1;
          end else if (stale_q) begin
            rd_cnt_d = '0;
            run_d    = '0;
            pend_d   = 1'b0;
            state_d  = S_REBLD;
          end else if (sum_q == '0) begin
            rsp_d.picked_index = '0;
            rsp_d.total_weight = 42'(sum_q);
            rsp_d.was_draw     = 1'b1;
            done_d             = 1'b1;
          end else begin
            state_d = S_MUL_LO;
          end
        end
      end

      S_REBLD: begin
        pend_d     = issue;
        pend_idx_d = rd_cnt_q[IDX_W-1:0];
        if (issue) begin
          rd_cnt_d = rd_cnt_q + CNT_W'(1);
        end
        if (pend_q) begin
          run_d = run_nx;
        end
        if (!issue && !pend_q) begin
          sum_d   = run_q;
          stale_d = 1'b0;
          if (run_q == '0) begin
            rsp_d.picked_index = '0;
            rsp_d.total_weight = 42'(run_q);
            rsp_d.was_draw     = 1'b1;
            done_d             = 1'b1;
            state_d            = S_IDLE;
          end else begin
            state_d = S_MUL_LO;
          end
        end
      end

      S_MUL_LO: begin
        prod_d  = mul_p;
        state_d = S_MUL_HI;
      end

      S_MUL_HI: begin
        // pivot = u * hi + ((u * lo) >> 32)
        prod_d  = mul_p + {32'b0, prod_q[63:32]};
        lo_d    = '0;
        hi_d    = IDX_W'(n_act - CNT_W'(1));
        state_d = S_RD;
      end

      S_RD: begin
        if (lo_q < hi_q) begin
          mid_d   = mid_c;
          state_d = S_CMP;
        end else begin
          rsp_d.picked_index = 10'(lo_q);
          rsp_d.total_weight = 42'(sum_q);
          rsp_d.was_draw     = 1'b1;
          done_d             = 1'b1;
          state_d            = S_IDLE;
        end
      end

      S_CMP: begin
        if (64'(p_rdata) > prod_q) begin
          hi_d = mid_q;
        end else begin
          lo_d = mid_q + IDX_W'(1);
        end
        state_d = S_RD;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      active_q <= ACTIVE_RESET;
      stale_q  <= 1'b1;
      sum_q    <= '0;
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      stale_q  <= stale_d;
      sum_q    <= sum_d;
      pend_q   <= pend_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q      <= run_d;
    rd_cnt_q   <= rd_cnt_d;
    pend_idx_q <= pend_idx_d;
    u_q        <= u_d;
    prod_q     <= prod_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    rsp_q      <= rsp_d;
  end

  // weight table, read during the rebuild walk
  wis_ram #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (WEIGHT_BITS)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .raddr_i (rd_cnt_q[IDX_W-1:0]),
    .rdata_o (w_rdata)
  );

  // running prefix sums, written by the rebuild, read by the search
  wis_ram #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (SUM_W)
  ) u_prefix_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (pend_idx_q),
    .wdata_i (run_nx),
    .raddr_i (mid_c),
    .rdata_o (p_rdata)
  );

endmodule

>>> verif/wis_checker.sv
// result checker of the weighted index sampler: bus monitor, sampler model and compare
module wis_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              busy_i,
  input  wis_pkg::req_t                     req_i,
  input  logic                              done_i,
  input  wis_pkg::rsp_t                     rsp_i,
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic [wis_pkg::CFG_ADDR_W-1:0]    paddr_i,
  input  logic [wis_pkg::CFG_DATA_W-1:0]    pwdata_i,
  input  logic [wis_pkg::CFG_DATA_W-1:0]    prdata_i,
  input  logic                              pready_i,
  output int unsigned                       faults_o,
  output int unsigned                       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import wis_pkg::*;

  localparam int unsigned TABLE_SIZE = DEF_MAX_ENTRIES;

  logic [31:0]         weight_mem [TABLE_SIZE];
  logic [41:0]         prefix_mem [TABLE_SIZE];
  logic [41:0]         total_q;
  logic                stale_q;
  logic [ACTIVE_W-1:0] active_q;

  rsp_t        answer_q[$];
  int unsigned fault_count = 0;

  task automatic flag_fault(input string msg);
    if (fault_count < 200) begin
      $display("%0t ns  mismatch: %s", $time, msg);
    end
    fault_count++;
  endtask

  // 0 behaves as one entry, anything past the table as the whole table
  function automatic int unsigned live_entries();
    if (active_q == '0) begin
      return 1;
    end
    if (active_q > TABLE_SIZE) begin
      return TABLE_SIZE;
    end
    return 32'(active_q);
  endfunction

  function automatic void rebuild_prefix_sums();
    logic [41:0] run;
    run = '0;
    for (int i = 0; i < live_entries(); i++) begin
      run = run + {10'b0, weight_mem[i]};
      prefix_mem[i] = run;
    end
    total_q = run;
    stale_q = 1'b0;
  endfunction

  // exact floor(u * total / 2^32), always below the total
  function automatic logic [41:0] scale_fraction(input logic [31:0] u);
    logic [73:0] a;
    logic [73:0] b;
    logic [73:0] product;
    a = 74'(u);
    b = 74'(total_q);
    product = a * b;
    return product[73:32];
  endfunction

  // first live entry whose running sum exceeds the pivot
  function automatic logic [9:0] locate_entry(input logic [41:0] pivot);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = live_entries() - 1;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (prefix_mem[mid] > pivot) begin
        hi = mid;
      end else begin
        lo = mid + 1;
      end
    end
    return lo[9:0];
  endfunction

  function automatic rsp_t serve_request(input req_t rq);
    rsp_t ans;
    ans = '0;
    if (rq.operation == OP_WRITE) begin
      // the index field cannot leave the table, so every write lands
      weight_mem[rq.entry_index] = rq.weight_value;
      stale_q = 1'b1;
      ans.total_weight = total_q;
      ans.was_draw = 1'b0;
    end else begin
      if (stale_q) begin
        rebuild_prefix_sums();
      end
      if (total_q != '0) begin
        ans.picked_index = locate_entry(scale_fraction(rq.uniform_fraction));
      end
      ans.total_weight = total_q;
      ans.was_draw = 1'b1;
    end
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      answer_q.delete();
      total_q = '0;
      stale_q = 1'b1;
      active_q = ACTIVE_RESET;
      pending_o <= 0;
      faults_o <= 0;
    end else begin
      if (done_i) begin
        if (answer_q.size() == 0) begin
          flag_fault($sformatf("result with no request outstanding: %p", rsp_i));
        end else begin
          want = answer_q.pop_front();
          if (rsp_i.picked_index !== want.picked_index) begin
            flag_fault($sformatf("picked_index got %0d want %0d",
                                 rsp_i.picked_index, want.picked_index));
          end
          if (rsp_i.total_weight !== want.total_weight) begin
            flag_fault($sformatf("total_weight got 0x%0h want 0x%0h",
                                 rsp_i.total_weight, want.total_weight));
          end
          if (rsp_i.was_draw !== want.was_draw) begin
            flag_fault($sformatf("was_draw got %0b want %0b",
                                 rsp_i.was_draw, want.was_draw));
          end
        end
      end
      if (psel_i && penable_i && pready_i &&
          paddr_i[CFG_ADDR_W-1:2] == REG_ACTIVE_ENTRIES) begin
        if (pwrite_i) begin
          active_q = pwdata_i[ACTIVE_W-1:0];
          stale_q = 1'b1;
        end else if (prdata_i[ACTIVE_W-1:0] !== active_q) begin
          flag_fault($sformatf("active_entries read 0x%0h want 0x%0h",
                               prdata_i[ACTIVE_W-1:0], active_q));
        end
      end
      if (start_i && !busy_i) begin
        answer_q = {answer_q, serve_request(req_i)};
      end
      pending_o <= answer_q.size();
      faults_o <= fault_count;
    end
  end

endmodule

>>> verif/weighted_index_sampler_tb.sv
// top of the weighted index sampler testbench: clock, reset, stimulus and verdict
module weighted_index_sampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wis_pkg::*;

  // worst correct draw: a stale rebuild over 1024 entries plus the search; the run
  // has well under 300 such draws and under 2000 requests with sender gaps of at
  // most MAX_GAP, so this leaves a wide margin
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  // quiet time after the last result so a stray strobe is still caught
  localparam int unsigned DRAIN_CYCLES = 1100;
  localparam int unsigned MAX_GAP      = 40;
  localparam int unsigned N_PHASES     = 9;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  start_i = 1'b0;
  req_t                  req_i = '0;
  logic                  busy_o;
  logic                  done_o;
  rsp_t                  rsp_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned faults;
  int unsigned pending;
  int unsigned cycle_count = 0;
  // chance in percent that the sender adds another idle cycle after a request
  int unsigned idle_pct = 0;

  // random phases: active_entries setting, sender idle percent, request count
  // small tables carry most requests, the whole table only a few dozen
  int unsigned phase_active [N_PHASES] = '{1, 2047, 5, 1024, 64, 513, 0, 3, 17};
  int unsigned phase_idle   [N_PHASES] = '{0, 80, 18, 0, 80, 18, 0, 80, 18};
  int unsigned phase_items  [N_PHASES] = '{25, 15, 45, 15, 45, 20, 30, 35, 30};

  weighted_index_sampler u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .req_i   (req_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .rsp_o   (rsp_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  wis_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_i    (busy_o),
    .req_i     (req_i),
    .done_i    (done_o),
    .rsp_i     (rsp_o),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_i  (prdata),
    .pready_i  (pready),
    .faults_o  (faults),
    .pending_o (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs or never answers
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("weighted_index_sampler regression: fail");
      $finish;
    end
  end

  // mostly nonzero weights, with zeros and the full 32-bit value mixed in
  function automatic logic [31:0] pick_weight();
    case ($urandom_range(9))
      0, 1:    return '0;
      2:       return 32'hFFFF_FFFF;
      3, 4:    return $urandom_range(1, 15);
      default: return $urandom;
    endcase
  endfunction

  // weight write request; the fraction field is don't-care and gets noise
  function automatic req_t mk_write(input logic [9:0] slot, input logic [31:0] weight);
    req_t rq;
    rq.operation = OP_WRITE;
    rq.entry_index = slot;
    rq.weight_value = weight;
    rq.uniform_fraction = $urandom;
    return rq;
  endfunction

  // draw request; index and weight fields are don't-care and get noise
  function automatic req_t mk_draw(input logic [31:0] frac);
    req_t rq;
    rq.operation = OP_DRAW;
    rq.entry_index = 10'($urandom);
    rq.weight_value = $urandom;
    rq.uniform_fraction = frac;
    return rq;
  endfunction

  // holds start until the block takes the request, then maybe idles a while;
  // start stays high when no gap follows so back-to-back requests need one assignment
  task automatic issue(input req_t rq);
    int unsigned gap;
    gap = 0;
    start_i <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy_o);
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
      gap++;
    end
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop sending and wait for every outstanding answer and a quiet block
  task automatic wait_idle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy_o);
    repeat (2) @(posedge clk_i);
  endtask

  // one apb transfer to active_entries: setup cycle, access until pready,
  // then an idle phase with psel low before the next transfer
  task automatic apb_access(input logic wr, input logic [CFG_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {REG_ACTIVE_ENTRIES, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // reprogram the table size while idle, junk in the unused upper data bits,
  // then read it back for the checker
  task automatic set_active(input int unsigned count);
    logic [CFG_DATA_W-1:0] data;
    wait_idle();
    data = ($urandom & ~32'h7FF) | (count & 32'h7FF);
    apb_access(1'b1, data);
    apb_access(1'b0, '0);
  endtask

  initial begin
    int unsigned span;
    int unsigned sent;
    int unsigned burst;
    int unsigned draws;
    logic [31:0] frac;
    logic [9:0]  slot;
    logic [95:0] noise;
    req_t        rq;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset value of the register, then a one-entry table before any draw
    // so no rebuild ever touches a weight that was never written
    apb_access(1'b0, '0);
    set_active(1);

    // zero total answers entry 0 at both fraction extremes
    issue(mk_write(10'd0, 32'd0));
    issue(mk_draw(32'd0));
    issue(mk_draw(32'hFFFF_FFFF));
    // full-scale weight and fraction
    issue(mk_write(10'd0, 32'hFFFF_FFFF));
    issue(mk_draw(32'hFFFF_FFFF));
    // write outside the live set: ack shows the old total, draw ignores the entry
    issue(mk_write(10'd1023, 32'd5));
    issue(mk_draw(32'h8000_0000));

    // a count of zero behaves as a single entry
    set_active(0);
    issue(mk_draw(32'hFFFF_FFFF));

    // two entries: fraction extremes pick either end
    set_active(2);
    issue(mk_write(10'd1, 32'd5));
    issue(mk_draw(32'hFFFF_FFFF));
    issue(mk_draw(32'd0));

    // zero-weight entry in the middle is skipped; fractions straddle the 3/7 step
    set_active(3);
    issue(mk_write(10'd0, 32'd3));
    issue(mk_write(10'd1, 32'd0));
    issue(mk_write(10'd2, 32'd4));
    issue(mk_draw(32'h6DB6_DB6D));
    issue(mk_draw(32'h6DB6_DB6E));
    issue(mk_draw(32'h6DB6_DB6F));
    issue(mk_draw(32'hFFFF_FFFF));
    // every live weight back to zero: zero total over several entries
    issue(mk_write(10'd2, 32'd0));
    issue(mk_write(10'd0, 32'd0));
    issue(mk_draw(32'h1234_5678));

    // preload the whole table so any table size is safe from here on
    for (int i = 0; i < DEF_MAX_ENTRIES; i++) begin
      issue(mk_write(i[9:0], pick_weight()));
    end

    for (int p = 0; p < N_PHASES; p++) begin
      set_active(phase_active[p]);
      idle_pct = phase_idle[p];
      span = phase_active[p] == 0 ? 1 :
             phase_active[p] > DEF_MAX_ENTRIES ? DEF_MAX_ENTRIES : phase_active[p];
      sent = 0;
      while (sent < phase_items[p]) begin
        if ($urandom_range(99) < 15) begin
          // noise: any operation with every field random
          noise = {$urandom, $urandom, $urandom};
          rq = noise[$bits(req_t)-1:0];
          issue(rq);
          sent++;
        end else begin
          // typical use: a few weight updates, then a run of draws
          burst = $urandom_range(3);
          draws = $urandom_range(1, 5);
          for (int w = 0; w < burst; w++) begin
            slot = ($urandom_range(99) < 80) ? 10'($urandom_range(span - 1)) :
                                               10'($urandom);
            issue(mk_write(slot, pick_weight()));
          end
          for (int d = 0; d < draws; d++) begin
            case ($urandom_range(9))
              0:       frac = '0;
              1:       frac = 32'hFFFF_FFFF;
              default: frac = $urandom;
            endcase
            issue(mk_draw(frac));
          end
          sent += burst + draws;
        end
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (faults == 0 && pending == 0) begin
      $display("weighted_index_sampler regression: pass");
    end else begin
      $display("weighted_index_sampler regression: fail");
    end
    $finish;
  end

endmodule
